### sv/tpqm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpqm_pkg
// Shared types and constants of the touch point qualifier and mapper.
// ----------------------------------------------------------------------------
package tpqm_pkg;

    localparam int unsigned RAW_W   = 12;
    localparam int unsigned PROD_W  = 2 * RAW_W;
    localparam int unsigned ORIENT_W = 3;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CNT_W   = 5;

    localparam logic [RAW_W-1:0] RAW_FULL = 12'd4095;

    typedef enum logic [2:0] {
        REG_H_RAW_MIN    = 3'd0,
        REG_H_RAW_MAX    = 3'd1,
        REG_V_RAW_MIN    = 3'd2,
        REG_V_RAW_MAX    = 3'd3,
        REG_H_RESOLUTION = 3'd4,
        REG_V_RESOLUTION = 3'd5,
        REG_ORIENTATION  = 3'd6,
        REG_RAW_TOL      = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_ZONE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic load_mul;
        logic div_step;
        logic fin_axis;
        logic load_zone;
        logic load_out;
    } t_ctrl;

endpackage : tpqm_pkg
`default_nettype wire

### sv/touch_point_qualify_and_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_point_qualify_and_map
// Qualifies three repeat raw touch readings per axis and maps an accepted
// touch from the calibrated raw window to screen pixels.
// ----------------------------------------------------------------------------
// One request is taken at a time and the block is not ready while it works.
// A rejected touch goes from acceptance through the zone state to the output
// state, where its result is loaded, and the block then takes the next
// request. An accepted touch is scaled per axis by one shared 12x12
// multiplier and one restoring divider that produces one quotient bit a
// cycle, used twice (24 steps per axis), plus a multiply for the zone index,
// before its result is loaded. The result sits in an output register, so a
// new request may be accepted while it waits; if the previous result is
// still unaccepted when the next one is done, the block holds until it is
// taken.
// Calibration registers are written through the APB port at byte address
// 4*index and read back at the same address.
module touch_point_qualify_and_map (
    input  wire                          i_clk,
    input  wire                          i_rst_n,

    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [tpqm_pkg::ADDR_W-1:0]   paddr,
    input  wire [tpqm_pkg::DATA_W-1:0]   pwdata,
    output logic [tpqm_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,

    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [tpqm_pkg::RAW_W-1:0]    i_raw_x_first,
    input  wire [tpqm_pkg::RAW_W-1:0]    i_raw_y_first,
    input  wire [tpqm_pkg::RAW_W-1:0]    i_raw_x_second,
    input  wire [tpqm_pkg::RAW_W-1:0]    i_raw_y_second,
    input  wire [tpqm_pkg::RAW_W-1:0]    i_raw_x_third,
    input  wire [tpqm_pkg::RAW_W-1:0]    i_raw_y_third,

    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic                         o_pressed,
    output logic [tpqm_pkg::RAW_W-1:0]   o_pixel_x,
    output logic [tpqm_pkg::RAW_W-1:0]   o_pixel_y,
    output logic [tpqm_pkg::PROD_W-1:0]  o_zone
);
    import tpqm_pkg::*;

    function automatic logic within_tol(
        input logic [RAW_W-1:0] a,
        input logic [RAW_W-1:0] b,
        input logic [RAW_W-1:0] tol
    );
        logic [RAW_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return (d <= tol);
    endfunction

    // configuration registers
    logic [RAW_W-1:0]    r_h_min, r_h_max, r_v_min, r_v_max;
    logic [RAW_W-1:0]    r_h_res, r_v_res, r_tol;
    logic [ORIENT_W-1:0] r_orient;

    // sequencer and datapath
    t_state              r_state, n_state;
    t_ctrl               ctrl;
    logic                r_axis;
    logic                r_ok;
    logic                r_zero;
    logic [RAW_W-1:0]    r_xf, r_yf;
    logic [RAW_W-1:0]    r_den;
    logic [RAW_W-1:0]    r_rem;
    logic [PROD_W-1:0]   r_prod;
    logic [CNT_W-1:0]    r_cnt;
    logic [RAW_W-1:0]    r_nx;
    logic [RAW_W-1:0]    r_held_x, r_held_y;

    logic                cfg_wr;
    t_reg_idx            cfg_idx;
    logic                in_fire;
    logic                in_ok;
    logic                swap;
    logic [RAW_W-1:0]    ax_raw, ax_lo, ax_hi, ax_res;
    logic                ax_flip;
    logic [RAW_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [RAW_W:0]      trial;
    logic [RAW_W:0]      trial_sub;
    logic                q_bit;
    logic [RAW_W-1:0]    q_clamp;
    logic [RAW_W-1:0]    q_final;
    logic                div_last;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_H_RAW_MIN:    prdata = DATA_W'(r_h_min);
            REG_H_RAW_MAX:    prdata = DATA_W'(r_h_max);
            REG_V_RAW_MIN:    prdata = DATA_W'(r_v_min);
            REG_V_RAW_MAX:    prdata = DATA_W'(r_v_max);
            REG_H_RESOLUTION: prdata = DATA_W'(r_h_res);
            REG_V_RESOLUTION: prdata = DATA_W'(r_v_res);
            REG_ORIENTATION:  prdata = DATA_W'(r_orient);
            REG_RAW_TOL:      prdata = DATA_W'(r_tol);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_min  <= 12'd30;
            r_h_max  <= 12'd4065;
            r_v_min  <= 12'd30;
            r_v_max  <= 12'd4065;
            r_h_res  <= 12'd240;
            r_v_res  <= 12'd320;
            r_orient <= 3'd7;
            r_tol    <= 12'd10;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_H_RAW_MIN:    r_h_min  <= pwdata[RAW_W-1:0];
                REG_H_RAW_MAX:    r_h_max  <= pwdata[RAW_W-1:0];
                REG_V_RAW_MIN:    r_v_min  <= pwdata[RAW_W-1:0];
                REG_V_RAW_MAX:    r_v_max  <= pwdata[RAW_W-1:0];
                REG_H_RESOLUTION: r_h_res  <= pwdata[RAW_W-1:0];
                REG_V_RESOLUTION: r_v_res  <= pwdata[RAW_W-1:0];
                REG_ORIENTATION:  r_orient <= pwdata[ORIENT_W-1:0];
                REG_RAW_TOL:      r_tol    <= pwdata[RAW_W-1:0];
                default:          r_tol    <= r_tol;
            endcase
        end
    end

    // request qualification
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_ok      = within_tol(i_raw_x_first, i_raw_x_second, r_tol)
                     && within_tol(i_raw_y_first, i_raw_y_second, r_tol)
                     && within_tol(i_raw_x_first, i_raw_x_third, r_tol)
                     && within_tol(i_raw_y_first, i_raw_y_third, r_tol)
                     && (i_raw_x_first != '0) && (i_raw_x_first != RAW_FULL)
                     && (i_raw_y_first != '0) && (i_raw_y_first != RAW_FULL);

    // axis operand selection
    assign swap = r_orient[0];
    always_comb begin
        if (r_axis ^ swap) begin
            ax_raw = r_yf;
            ax_lo  = r_v_min;
            ax_hi  = r_v_max;
            ax_res = r_v_res;
        end else begin
            ax_raw = r_xf;
            ax_lo  = r_h_min;
            ax_hi  = r_h_max;
            ax_res = r_h_res;
        end
        ax_flip = r_axis ? r_orient[2] : r_orient[1];
    end

    // shared multiplier
    always_comb begin
        if (r_state == ST_ZONE) begin
            mul_a = r_held_y;
            mul_b = r_h_res;
        end else begin
            mul_a = ax_raw - ax_lo;
            mul_b = ax_res;
        end
    end
    assign mul_p = mul_a * mul_b;

    // restoring divider step
    assign trial     = {r_rem, r_prod[PROD_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign q_bit     = (trial >= {1'b0, r_den});
    assign div_last  = (r_cnt == CNT_W'(PROD_W - 1));

    // clamp and flip of the finished quotient
    always_comb begin
        if (r_zero) begin
            q_clamp = '0;
        end else if (r_prod > PROD_W'(ax_res)) begin
            q_clamp = ax_res;
        end else begin
            q_clamp = r_prod[RAW_W-1:0];
        end
        q_final = ax_flip ? (ax_res - q_clamp) : q_clamp;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_fire) n_state = in_ok ? ST_MUL : ST_ZONE;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  if (div_last) n_state = ST_FIN;
            ST_FIN:  n_state = r_axis ? ST_ZONE : ST_MUL;
            ST_ZONE: n_state = ST_OUT;
            ST_OUT:  if (!o_out_valid || i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctrl = '0;
        unique case (r_state)
            ST_IDLE: ctrl.load_in   = in_fire;
            ST_MUL:  ctrl.load_mul  = 1'b1;
            ST_DIV:  ctrl.div_step  = 1'b1;
            ST_FIN:  ctrl.fin_axis  = 1'b1;
            ST_ZONE: ctrl.load_zone = 1'b1;
            ST_OUT:  ctrl.load_out  = !o_out_valid || i_out_ready;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= 1'b0;
            r_held_x    <= '0;
            r_held_y    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctrl.load_in) begin
                r_axis <= 1'b0;
            end
            if (ctrl.fin_axis) begin
                r_axis <= 1'b1;
                if (r_axis) begin
                    r_held_x <= r_nx;
                    r_held_y <= q_final;
                end
            end
            if (ctrl.load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.load_in) begin
            r_xf <= i_raw_x_first;
            r_yf <= i_raw_y_first;
            r_ok <= in_ok;
        end
        if (ctrl.load_mul) begin
            r_prod <= mul_p;
            r_den  <= ax_hi - ax_lo;
            r_zero <= (ax_raw <= ax_lo) || (ax_hi <= ax_lo);
            r_rem  <= '0;
            r_cnt  <= '0;
        end
        if (ctrl.div_step) begin
            r_rem  <= q_bit ? trial_sub[RAW_W-1:0] : trial[RAW_W-1:0];
            r_prod <= {r_prod[PROD_W-2:0], q_bit};
            r_cnt  <= r_cnt + 1'b1;
        end
        if (ctrl.fin_axis && !r_axis) begin
            r_nx <= q_final;
        end
        if (ctrl.load_zone) begin
            r_prod <= mul_p;
        end
        if (ctrl.load_out) begin
            o_pressed <= r_ok;
            o_pixel_x <= r_held_x;
            o_pixel_y <= r_held_y;
            o_zone    <= r_prod + PROD_W'(r_held_x);
        end
    end

endmodule : touch_point_qualify_and_map
`default_nettype wire

### tb/sv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for touch_point_qualify_and_map. A directed table
// covers reset state, rejects at the raw limits and the tolerance edge.
// Calibration phases follow, three fixed and the rest random, all with the
// same random request mix and all checked against an in-bench model of
// qualification, scaling, orientation and the held point.
// ----------------------------------------------------------------------------
module tb;
    import tpqm_pkg::*;

    typedef struct packed {
        logic [RAW_W-1:0] xf, yf, xs, ys, xt, yt;
    } t_touch;

    typedef struct packed {
        logic              pressed;
        logic [RAW_W-1:0]  px;
        logic [RAW_W-1:0]  py;
        logic [PROD_W-1:0] zone;
    } t_point;

    typedef struct packed {
        t_touch raw;
        logic   typed;
        t_point want;
    } t_row;

    localparam int N_DIRECTED = 14;
    localparam int N_PHASES   = 12;
    localparam int PHASE_LEN  = 125;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel, penable, pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [RAW_W-1:0]    i_raw_x_first, i_raw_y_first, i_raw_x_second;
    logic [RAW_W-1:0]    i_raw_y_second, i_raw_x_third, i_raw_y_third;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_pressed;
    logic [RAW_W-1:0]    o_pixel_x, o_pixel_y;
    logic [PROD_W-1:0]   o_zone;

    logic [RAW_W-1:0]    cal [8];
    logic [RAW_W-1:0]    held_x, held_y;
    t_point              pending_points [$];
    t_row                directed [N_DIRECTED];
    int unsigned         n_sent;
    bit                  failed;

    touch_point_qualify_and_map uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_raw_x_first  (i_raw_x_first),
        .i_raw_y_first  (i_raw_y_first),
        .i_raw_x_second (i_raw_x_second),
        .i_raw_y_second (i_raw_y_second),
        .i_raw_x_third  (i_raw_x_third),
        .i_raw_y_third  (i_raw_y_third),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pressed      (o_pressed),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_zone         (o_zone)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [RAW_W-1:0] raw_gap(input logic [RAW_W-1:0] a, b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [RAW_W-1:0] scale_axis(input logic [RAW_W-1:0] raw, lo, hi, res);
        longint r, l, h, s, q;
        r = raw;
        l = lo;
        h = hi;
        s = res;
        if (h <= l) q = 0;
        else q = (r - l) * s / (h - l);
        if (q < 0) q = 0;
        if (q > s) q = s;
        return q[RAW_W-1:0];
    endfunction

    // qualify, map and hold one touch
    function automatic t_point predict_touch(input t_touch t);
        t_point           p;
        logic             ok;
        logic [RAW_W-1:0] nx, ny, xres, yres, tol;
        tol = cal[REG_RAW_TOL];
        ok = raw_gap(t.xf, t.xs) <= tol && raw_gap(t.yf, t.ys) <= tol &&
             raw_gap(t.xf, t.xt) <= tol && raw_gap(t.yf, t.yt) <= tol &&
             t.xf != '0 && t.xf != RAW_FULL && t.yf != '0 && t.yf != RAW_FULL;
        if (ok) begin
            if (cal[REG_ORIENTATION][0]) begin
                xres = cal[REG_V_RESOLUTION];
                yres = cal[REG_H_RESOLUTION];
                nx = scale_axis(t.yf, cal[REG_V_RAW_MIN], cal[REG_V_RAW_MAX], xres);
                ny = scale_axis(t.xf, cal[REG_H_RAW_MIN], cal[REG_H_RAW_MAX], yres);
            end else begin
                xres = cal[REG_H_RESOLUTION];
                yres = cal[REG_V_RESOLUTION];
                nx = scale_axis(t.xf, cal[REG_H_RAW_MIN], cal[REG_H_RAW_MAX], xres);
                ny = scale_axis(t.yf, cal[REG_V_RAW_MIN], cal[REG_V_RAW_MAX], yres);
            end
            if (cal[REG_ORIENTATION][1]) nx = xres - nx;
            if (cal[REG_ORIENTATION][2]) ny = yres - ny;
            held_x = nx;
            held_y = ny;
        end
        p.pressed = ok;
        p.px = held_x;
        p.py = held_y;
        p.zone = {12'd0, held_x} + held_y * cal[REG_H_RESOLUTION];
        return p;
    endfunction

    // repeat reading within tolerance of the first
    function automatic logic [RAW_W-1:0] jitter(input logic [RAW_W-1:0] base, tol);
        int v, d;
        d = $urandom_range(tol);
        if ($urandom_range(1)) d = -d;
        v = int'(base) + d;
        if (v < 0) v = 0;
        if (v > int'(RAW_FULL)) v = int'(RAW_FULL);
        return v[RAW_W-1:0];
    endfunction

    // repeat reading just outside tolerance, needs tol below 2000
    function automatic logic [RAW_W-1:0] stray(input logic [RAW_W-1:0] base, tol);
        int d, up, dn;
        d = int'(tol) + 1 + $urandom_range(15);
        up = int'(base) + d;
        dn = int'(base) - d;
        if (up > int'(RAW_FULL) || (dn >= 0 && $urandom_range(1))) return dn[RAW_W-1:0];
        return up[RAW_W-1:0];
    endfunction

    function automatic t_touch make_touch();
        t_touch           t;
        int unsigned      pick;
        logic [RAW_W-1:0] tol;
        tol = cal[REG_RAW_TOL];
        pick = $urandom_range(99);
        if (pick >= 88) begin
            t.xf = 12'($urandom);
            t.yf = 12'($urandom);
            t.xs = 12'($urandom);
            t.ys = 12'($urandom);
            t.xt = 12'($urandom);
            t.yt = 12'($urandom);
            return t;
        end
        if (pick < 15) begin
            // near the calibration window edges
            t.xf = jitter($urandom_range(1) ? cal[REG_H_RAW_MIN] : cal[REG_H_RAW_MAX], 2);
            t.yf = jitter($urandom_range(1) ? cal[REG_V_RAW_MIN] : cal[REG_V_RAW_MAX], 2);
            if (t.xf == '0) t.xf = 12'd1;
            if (t.xf == RAW_FULL) t.xf = RAW_FULL - 12'd1;
            if (t.yf == '0) t.yf = 12'd1;
            if (t.yf == RAW_FULL) t.yf = RAW_FULL - 12'd1;
        end else begin
            t.xf = 12'($urandom_range(1, RAW_FULL - 1));
            t.yf = 12'($urandom_range(1, RAW_FULL - 1));
        end
        t.xs = jitter(t.xf, tol);
        t.ys = jitter(t.yf, tol);
        t.xt = jitter(t.xf, tol);
        t.yt = jitter(t.yf, tol);
        if (pick >= 70) begin
            case (tol < 2000 ? $urandom_range(4) : 4)
                0: t.xs = stray(t.xf, tol);
                1: t.ys = stray(t.yf, tol);
                2: t.xt = stray(t.xf, tol);
                3: t.yt = stray(t.yf, tol);
                default: begin
                    if ($urandom_range(1)) t.xf = $urandom_range(1) ? RAW_FULL : '0;
                    else t.yf = $urandom_range(1) ? RAW_FULL : '0;
                end
            endcase
        end
        return t;
    endfunction

    task automatic write_cal(input t_reg_idx idx, input logic [RAW_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        cal[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic send_touch(input t_touch t, input logic typed, input t_point want);
        int unsigned gap_pct;
        t_point      got;
        gap_pct = (n_sent < 500) ? 23 : (n_sent < 1000) ? 69 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_x_first <= t.xf;
        i_raw_y_first <= t.yf;
        i_raw_x_second <= t.xs;
        i_raw_y_second <= t.ys;
        i_raw_x_third <= t.xt;
        i_raw_y_third <= t.yt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        got = predict_touch(t);
        pending_points.push_back(typed ? want : got);
        n_sent++;
    endtask

    task automatic drain_points();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : collect
        t_point      want;
        int unsigned stall_pct;
        stall_pct = (n_sent < 500) ? 69 : (n_sent < 1000) ? 23 : 0;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_points.size() == 0) begin
                    $error("result with no request pending");
                    failed = 1'b1;
                end else begin
                    want = pending_points.pop_front();
                    if (o_pressed !== want.pressed) begin
                        $error("pressed: expected %0d, got %0d", want.pressed, o_pressed);
                        failed = 1'b1;
                    end
                    if (o_pixel_x !== want.px) begin
                        $error("pixel_x: expected %0d, got %0d", want.px, o_pixel_x);
                        failed = 1'b1;
                    end
                    if (o_pixel_y !== want.py) begin
                        $error("pixel_y: expected %0d, got %0d", want.py, o_pixel_y);
                        failed = 1'b1;
                    end
                    if (o_zone !== want.zone) begin
                        $error("zone: expected %0d, got %0d", want.zone, o_zone);
                        failed = 1'b1;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #(12 * 1000000);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic [RAW_W-1:0] next_cal [8];
        logic [RAW_W-1:0] lo;

        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_in_valid <= 1'b0;
        i_raw_x_first <= '0;
        i_raw_y_first <= '0;
        i_raw_x_second <= '0;
        i_raw_y_second <= '0;
        i_raw_x_third <= '0;
        i_raw_y_third <= '0;
        n_sent = 0;
        failed = 1'b0;
        cal[REG_H_RAW_MIN] = 30;
        cal[REG_H_RAW_MAX] = 4065;
        cal[REG_V_RAW_MIN] = 30;
        cal[REG_V_RAW_MAX] = 4065;
        cal[REG_H_RESOLUTION] = 240;
        cal[REG_V_RESOLUTION] = 320;
        cal[REG_ORIENTATION] = 7;
        cal[REG_RAW_TOL] = 10;
        held_x = '0;
        held_y = '0;

        // reset calibration: swapped and both flipped, tolerance 10
        directed[0]  = '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b1, '0};
        directed[1]  = '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095},
                         1'b1, '0};
        directed[2]  = '{'{12'd2048, 12'd0, 12'd2048, 12'd0, 12'd2048, 12'd0}, 1'b1, '0};
        directed[3]  = '{'{12'd2048, 12'd2048, 12'd2059, 12'd2048, 12'd2048, 12'd2048},
                         1'b1, '0};
        directed[4]  = '{'{12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd2059},
                         1'b1, '0};
        directed[5]  = '{'{12'd2048, 12'd2048, 12'd2058, 12'd2038, 12'd2038, 12'd2058},
                         1'b0, '0};
        directed[6]  = '{'{12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1}, 1'b0, '0};
        directed[7]  = '{'{12'd4094, 12'd4094, 12'd4094, 12'd4094, 12'd4094, 12'd4094},
                         1'b0, '0};
        directed[8]  = '{'{12'd30, 12'd4065, 12'd30, 12'd4065, 12'd30, 12'd4065}, 1'b0, '0};
        directed[9]  = '{'{12'd4065, 12'd30, 12'd4065, 12'd30, 12'd4065, 12'd30}, 1'b0, '0};
        directed[10] = '{'{12'd4095, 12'd1000, 12'd4095, 12'd1000, 12'd4095, 12'd1000},
                         1'b0, '0};
        directed[11] = '{'{12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd989, 12'd1000},
                         1'b0, '0};
        directed[12] = '{'{12'd1234, 12'd3456, 12'd1230, 12'd3460, 12'd1239, 12'd3450},
                         1'b0, '0};
        directed[13] = '{'{12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555}, 1'b0, '0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_touch(directed[i].raw, directed[i].typed, directed[i].want);
        drain_points();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    // widest window, full resolution, exact repeats only
                    next_cal[REG_H_RAW_MIN] = 0;
                    next_cal[REG_H_RAW_MAX] = 4095;
                    next_cal[REG_V_RAW_MIN] = 0;
                    next_cal[REG_V_RAW_MAX] = 4095;
                    next_cal[REG_H_RESOLUTION] = 4095;
                    next_cal[REG_V_RESOLUTION] = 4095;
                    next_cal[REG_ORIENTATION] = 0;
                    next_cal[REG_RAW_TOL] = 0;
                end
                1: begin
                    // degenerate windows, equal and reversed
                    next_cal[REG_H_RAW_MIN] = 2000;
                    next_cal[REG_H_RAW_MAX] = 2000;
                    next_cal[REG_V_RAW_MIN] = 3000;
                    next_cal[REG_V_RAW_MAX] = 1000;
                    next_cal[REG_H_RESOLUTION] = 4095;
                    next_cal[REG_V_RESOLUTION] = 1;
                    next_cal[REG_ORIENTATION] = 6;
                    next_cal[REG_RAW_TOL] = 4095;
                end
                2: begin
                    // one-count windows at both ends
                    next_cal[REG_H_RAW_MIN] = 4094;
                    next_cal[REG_H_RAW_MAX] = 4095;
                    next_cal[REG_V_RAW_MIN] = 0;
                    next_cal[REG_V_RAW_MAX] = 1;
                    next_cal[REG_H_RESOLUTION] = 1;
                    next_cal[REG_V_RESOLUTION] = 4095;
                    next_cal[REG_ORIENTATION] = 1;
                    next_cal[REG_RAW_TOL] = 1;
                end
                default: begin
                    lo = 12'($urandom_range(4000));
                    next_cal[REG_H_RAW_MIN] = lo;
                    next_cal[REG_H_RAW_MAX] = ($urandom_range(9) == 0) ?
                        12'($urandom_range(lo)) : 12'($urandom_range(lo + 1, 4095));
                    lo = 12'($urandom_range(4000));
                    next_cal[REG_V_RAW_MIN] = lo;
                    next_cal[REG_V_RAW_MAX] = ($urandom_range(9) == 0) ?
                        12'($urandom_range(lo)) : 12'($urandom_range(lo + 1, 4095));
                    next_cal[REG_H_RESOLUTION] = $urandom_range(1) ?
                        12'($urandom_range(1, 512)) : 12'($urandom_range(1, 4095));
                    next_cal[REG_V_RESOLUTION] = $urandom_range(1) ?
                        12'($urandom_range(1, 512)) : 12'($urandom_range(1, 4095));
                    next_cal[REG_ORIENTATION] = 12'(ph % 8);
                    next_cal[REG_RAW_TOL] = ($urandom_range(9) < 7) ?
                        12'($urandom_range(40)) : 12'($urandom_range(4095));
                end
            endcase
            for (int r = 0; r < 8; r++) write_cal(t_reg_idx'(r), next_cal[r]);
            for (int n = 0; n < PHASE_LEN; n++) send_touch(make_touch(), 1'b0, '0);
            drain_points();
        end

        repeat (60) @(posedge i_clk);
        if (!failed && pending_points.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
sv/tpqm_pkg.sv
sv/touch_point_qualify_and_map.sv
tb/sv/tb.sv
